// ===== design/lpct_pkg.sv =====
// Shared types and constants for the low-power compare timer.
// Holds the item words, request codes, register offsets and register bit positions.
// No dependencies.
package lpct_pkg;

	localparam int CNT_W  = 16;
	localparam int PRE_W  = 16;
	localparam int IDX_W  = 10;
	localparam int DATA_W = 32;
	localparam int SRC_W  = 3;
	localparam int CTRL_W = 7;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2
	} req_t;

	localparam logic [IDX_W-1:0] REG_CSR = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_PSR = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_CMR = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_CNR = IDX_W'(3);

	localparam int CSR_EN   = 0;
	localparam int CSR_FREE = 2;
	localparam int CSR_IE   = 6;
	localparam int CSR_FLAG = 7;
	localparam int PSR_BYP  = 2;
	localparam int PSR_PRE  = 3;

	localparam logic [1:0] SRC_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [IDX_W-1:0]  reg_index;
		logic [DATA_W-1:0] write_data;
		logic [SRC_W-1:0]  source_edges;
	} in_word_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq_level;
		logic              trigger_pulse;
	} out_word_t;

endpackage

// ===== design/lpct_in_if.sv =====
// Request channel of the low-power compare timer: valid, ready and one request word.
// Depends on lpct_pkg.
interface lpct_in_if
	import lpct_pkg::*;
();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/lpct_out_if.sv =====
// Response channel of the low-power compare timer: valid, ready and one response word.
// Depends on lpct_pkg.
interface lpct_out_if
	import lpct_pkg::*;
();
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/lpct_core.sv =====
// Timer state, register file, prescaler and compare logic.
// Applies one request word per fire strobe; depends on lpct_pkg.
module lpct_core
	import lpct_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_word_t  item,
	output out_word_t result
);

	logic [CTRL_W-1:0] ctrl_q, ctrl_d;
	logic              flag_q, flag_d;
	logic [CTRL_W-1:0] psr_q, psr_d;
	logic [CNT_W-1:0]  cmp_q, cmp_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [PRE_W-1:0]  pre_q, pre_d;

	logic [1:0]       sel;
	logic             edge_hit;
	logic [PRE_W:0]   pre_inc;
	logic [PRE_W:0]   div;
	logic             div_hit;
	logic             do_cnt;
	logic             match;
	logic [DATA_W-1:0] rd;
	logic             trig;

	assign sel      = psr_q[1:0];
	assign edge_hit = ctrl_q[CSR_EN] && (sel != SRC_NONE) && item.source_edges[sel];
	assign pre_inc  = {1'b0, pre_q} + (PRE_W+1)'(1);
	assign div      = (PRE_W+1)'(1) << ({1'b0, psr_q[PSR_PRE +: 4]} + 5'd1);
	assign div_hit  = pre_inc >= div;
	assign match    = cnt_q == cmp_q;

	always_comb begin
		ctrl_d = ctrl_q;
		flag_d = flag_q;
		psr_d  = psr_q;
		cmp_d  = cmp_q;
		cnt_d  = cnt_q;
		pre_d  = pre_q;
		rd     = '0;
		trig   = 1'b0;
		do_cnt = 1'b0;
		unique case (item.req_type)
			REQ_TICK: begin
				if (edge_hit) begin
					if (psr_q[PSR_BYP]) begin
						do_cnt = 1'b1;
					end else if (div_hit) begin
						pre_d  = '0;
						do_cnt = 1'b1;
					end else begin
						pre_d = pre_inc[PRE_W-1:0];
					end
				end
				if (do_cnt) begin
					if (match) begin
						flag_d = 1'b1;
						trig   = 1'b1;
					end
					if (match && !ctrl_q[CSR_FREE]) begin
						cnt_d = '0;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			REQ_READ: begin
				unique case (item.reg_index)
					REG_CSR: rd = DATA_W'({flag_q, ctrl_q});
					REG_PSR: rd = DATA_W'(psr_q);
					REG_CMR: rd = DATA_W'(cmp_q);
					REG_CNR: rd = DATA_W'(cnt_q);
					default: rd = '0;
				endcase
			end
			REQ_WRITE: begin
				unique case (item.reg_index)
					REG_CSR: begin
						if (item.write_data[CSR_FLAG]) begin
							flag_d = 1'b0;
						end
						ctrl_d = item.write_data[CTRL_W-1:0];
						if (!item.write_data[CSR_EN] || !ctrl_q[CSR_EN]) begin
							cnt_d = '0;
							pre_d = '0;
						end
					end
					REG_PSR: psr_d = item.write_data[CTRL_W-1:0];
					REG_CMR: cmp_d = item.write_data[CNT_W-1:0];
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign result.read_data     = rd;
	assign result.irq_level     = flag_d && ctrl_d[CSR_IE];
	assign result.trigger_pulse = trig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			flag_q <= 1'b0;
			psr_q  <= '0;
			cmp_q  <= '0;
			cnt_q  <= '0;
			pre_q  <= '0;
		end else if (fire) begin
			ctrl_q <= ctrl_d;
			flag_q <= flag_d;
			psr_q  <= psr_d;
			cmp_q  <= cmp_d;
			cnt_q  <= cnt_d;
			pre_q  <= pre_d;
		end
	end

endmodule

// ===== design/low_power_compare_timer.sv =====
// Top level of the low-power compare timer: request register, timer core, response register.
// Depends on lpct_pkg, lpct_in_if, lpct_out_if and lpct_core.

// Each request word (tick, register read or register write) yields one response word. A word
// taken into the request register moves into the response register when the response side
// can accept it, and its response then stays valid in the response register until it leaves.
// A new word is taken every cycle as long as the response side keeps up; the timer state is
// updated in the same cycle a word leaves the request register, so back-to-back ticks and bus
// accesses see each other's effects in order. A stalled response holds both stages.
module low_power_compare_timer
	import lpct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lpct_in_if.sink    req,
	lpct_out_if.source rsp
);

	logic      valid_s1;
	in_word_t  item_s1;
	logic      out_valid_q;
	out_word_t out_q;
	out_word_t result;
	logic      advance;
	logic      fire;

	assign advance   = !out_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	lpct_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule
